// File: hdl/tvg_pkg.sv
// Shared widths, register indexes and shading constants for the terrain vertex generator.
`default_nettype none

package tvg_pkg;

  localparam int COORD_W = 24;
  localparam int POS_W   = 25;
  localparam int NORM_W  = 8;
  localparam int TEX_W   = 5;
  localparam int SHADE_W = 8;
  localparam int OFF_W   = 14;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_X   = 2'd0,
    CFG_BASE_Y   = 2'd1,
    CFG_BASE_Z   = 2'd2,
    CFG_NORMALS  = 2'd3
  } cfg_idx_e;

  // Lambert shade: floor((SHADE_BIAS + 561 * clamp(dot, 0, DOT_MAX)) / 5080).
  // The sum is divided by 8 first, then by 635 through a reciprocal multiply.
  localparam int DOT_W        = 13;
  localparam int DOT_CLAMP_W  = 11;
  localparam int NUMER_W      = 21;
  localparam int NUMER8_W     = 18;
  localparam int RECIP_W      = 19;
  localparam int PROD_W       = NUMER8_W + RECIP_W;
  localparam int SHADE_SHIFT  = 28;

  localparam logic [DOT_CLAMP_W-1:0] DOT_MAX       = 11'd1270;
  localparam logic [NUMER_W-1:0]     SHADE_BIAS    = 21'd582930;
  localparam logic [RECIP_W-1:0]     SHADE_RECIP   = 19'd422734;
  localparam logic [SHADE_W-1:0]     SHADE_DEFAULT = 8'd204;

endpackage

`default_nettype wire

// File: hdl/tvg_cfg_if.sv
// Configuration write channel: register index and write data.
`default_nettype none

interface tvg_cfg_if import tvg_pkg::*;;
  logic                  valid;
  logic                  ready;
  cfg_idx_e              index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: hdl/tvg_in_if.sv
// Vertex request channel: height and signed normal of one vertex.
`default_nettype none

interface tvg_in_if import tvg_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] height;
  logic signed [NORM_W-1:0]  normal_x;
  logic signed [NORM_W-1:0]  normal_y;
  logic signed [NORM_W-1:0]  normal_z;

  modport source (output valid, output height, output normal_x, output normal_y,
                  output normal_z, input ready);
  modport sink   (input valid, input height, input normal_x, input normal_y,
                  input normal_z, output ready);
endinterface

`default_nettype wire

// File: hdl/tvg_out_if.sv
// Vertex result channel: position, texture coordinates, shade and chunk end flag.
`default_nettype none

interface tvg_out_if import tvg_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [POS_W-1:0] pos_z;
  logic [TEX_W-1:0]        tex_u;
  logic [TEX_W-1:0]        tex_v;
  logic [SHADE_W-1:0]      shade;
  logic                    last_vertex;

  modport source (output valid, output pos_x, output pos_y, output pos_z, output tex_u,
                  output tex_v, output shade, output last_vertex, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input pos_z, input tex_u,
                  input tex_v, input shade, input last_vertex, output ready);
endinterface

`default_nettype wire

// File: hdl/terrain_vertex_generator.sv
// Top level of the terrain vertex generator: grid walk, position, texture and shade.
`default_nettype none

// One vertex request is taken per clock cycle unless the result side stalls: the
// request is captured in an input register together with its row and column, and
// position, texture coordinates and shade are computed into the result register.
// The row and column counters advance on each accepted request and wrap after the
// last vertex of a chunk of 2*GRID_CELLS+1 rows. Throughput is one vertex per cycle
// whenever the result side takes results. Configuration writes are taken in every
// cycle and must only be issued while no vertex is in flight.

module terrain_vertex_generator import tvg_pkg::*; #(
  parameter int GRID_CELLS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tvg_cfg_if.sink     cfg_i,
  tvg_in_if.sink      vtx_i,
  tvg_out_if.source   vtx_o
);

  localparam int RowW = $clog2(2 * GRID_CELLS + 1);
  localparam int ColW = $clog2(GRID_CELLS + 1);
  localparam int HTab = 2 ** RowW;

  localparam logic [RowW-1:0] LastRow      = RowW'(2 * GRID_CELLS);
  localparam logic [ColW-1:0] LastColOuter = ColW'(GRID_CELLS);
  localparam logic [ColW-1:0] LastColInner = ColW'(GRID_CELLS - 1);

  logic [OFF_W-1:0] off_tab [HTab];
  logic [TEX_W-1:0] tex_tab [HTab];

  for (genvar h = 0; h < HTab; h++) begin : g_tab
    localparam int Off = (h <= 2 * GRID_CELLS) ?
                         (h * 25600 + 3 * GRID_CELLS) / (6 * GRID_CELLS) : 0;
    localparam int Tex = (h <= 2 * GRID_CELLS) ? (h * 8) / GRID_CELLS : 0;
    assign off_tab[h] = OFF_W'(Off);
    assign tex_tab[h] = TEX_W'(Tex);
  end

  logic signed [COORD_W-1:0] base_x_q;
  logic signed [COORD_W-1:0] base_y_q;
  logic signed [COORD_W-1:0] base_z_q;
  logic                      normals_present_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_x_q          <= '0;
      base_y_q          <= '0;
      base_z_q          <= '0;
      normals_present_q <= 1'b0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_BASE_X:  base_x_q          <= cfg_i.data;
        CFG_BASE_Y:  base_y_q          <= cfg_i.data;
        CFG_BASE_Z:  base_z_q          <= cfg_i.data;
        CFG_NORMALS: normals_present_q <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  logic [RowW-1:0] row_q, row_d;
  logic [ColW-1:0] col_q, col_d;
  logic            row_end;
  logic            in_fire;
  logic            s1_valid_q;
  logic            s1_ready;
  logic            s2_ready;
  logic            s1_fire;

  assign s2_ready    = !vtx_o.valid || vtx_o.ready;
  assign s1_ready    = !s1_valid_q || s2_ready;
  assign vtx_i.ready = s1_ready;
  assign in_fire     = vtx_i.valid && s1_ready;
  assign s1_fire     = s1_valid_q && s2_ready;

  assign row_end = row_q[0] ? (col_q == LastColInner) : (col_q == LastColOuter);

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (in_fire) begin
      if (row_end) begin
        col_d = '0;
        row_d = (row_q == LastRow) ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  logic signed [COORD_W-1:0] s1_height_q;
  logic signed [NORM_W-1:0]  s1_nx_q;
  logic signed [NORM_W-1:0]  s1_ny_q;
  logic signed [NORM_W-1:0]  s1_nz_q;
  logic [RowW-1:0]           s1_hr_q;
  logic [RowW-1:0]           s1_hc_q;
  logic                      s1_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= vtx_i.valid;
    end
  end

  // Inner rows sit half a cell over, so their column half-step index is odd.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_height_q <= vtx_i.height;
      s1_nx_q     <= vtx_i.normal_x;
      s1_ny_q     <= vtx_i.normal_y;
      s1_nz_q     <= vtx_i.normal_z;
      s1_hr_q     <= row_q;
      s1_hc_q     <= {col_q, row_q[0]};
      s1_last_q   <= (row_q == LastRow) && row_end;
    end
  end

  logic [SHADE_W-1:0] shade;

  tvg_shade u_shade (
    .normal_x_i        (s1_nx_q),
    .normal_y_i        (s1_ny_q),
    .normal_z_i        (s1_nz_q),
    .normals_present_i (normals_present_q),
    .shade_o           (shade)
  );

  logic                    out_valid_q;
  logic signed [POS_W-1:0] pos_x_q;
  logic signed [POS_W-1:0] pos_y_q;
  logic signed [POS_W-1:0] pos_z_q;
  logic [TEX_W-1:0]        tex_u_q;
  logic [TEX_W-1:0]        tex_v_q;
  logic [SHADE_W-1:0]      shade_q;
  logic                    last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      pos_x_q <= POS_W'(base_x_q) - POS_W'(off_tab[s1_hr_q]);
      pos_y_q <= POS_W'(base_y_q) - POS_W'(off_tab[s1_hc_q]);
      pos_z_q <= POS_W'(base_z_q) + POS_W'(s1_height_q);
      tex_u_q <= tex_tab[s1_hc_q];
      tex_v_q <= tex_tab[s1_hr_q];
      shade_q <= shade;
      last_q  <= s1_last_q;
    end
  end

  assign vtx_o.valid       = out_valid_q;
  assign vtx_o.pos_x       = pos_x_q;
  assign vtx_o.pos_y       = pos_y_q;
  assign vtx_o.pos_z       = pos_z_q;
  assign vtx_o.tex_u       = tex_u_q;
  assign vtx_o.tex_v       = tex_v_q;
  assign vtx_o.shade       = shade_q;
  assign vtx_o.last_vertex = last_q;

endmodule

`default_nettype wire

// File: hdl/tvg_shade.sv
// Lambert shade of one vertex normal against the fixed sun direction.
`default_nettype none

module tvg_shade import tvg_pkg::*; (
  input  logic signed [NORM_W-1:0] normal_x_i,
  input  logic signed [NORM_W-1:0] normal_y_i,
  input  logic signed [NORM_W-1:0] normal_z_i,
  input  logic                     normals_present_i,
  output logic [SHADE_W-1:0]       shade_o
);

  logic signed [DOT_W-1:0] nx_w;
  logic signed [DOT_W-1:0] ny_w;
  logic signed [DOT_W-1:0] nz_w;
  logic signed [DOT_W-1:0] dot;
  logic [DOT_CLAMP_W-1:0]  dot_clamped;
  logic [NUMER_W-1:0]      dot_ext;
  logic [NUMER_W-1:0]      numer;
  logic [PROD_W-1:0]       prod;

  assign nx_w = DOT_W'(normal_x_i);
  assign ny_w = DOT_W'(normal_y_i);
  assign nz_w = DOT_W'(normal_z_i);

  assign dot = (nz_w <<< 3) + nz_w - ((nx_w <<< 1) + nx_w) - ((ny_w <<< 1) + ny_w);

  always_comb begin
    priority if (dot < 0) begin
      dot_clamped = '0;
    end else if (dot > $signed({2'b00, DOT_MAX})) begin
      dot_clamped = DOT_MAX;
    end else begin
      dot_clamped = dot[DOT_CLAMP_W-1:0];
    end
  end

  // The weight 561 is 512 + 32 + 16 + 1.
  assign dot_ext = NUMER_W'(dot_clamped);
  assign numer   = SHADE_BIAS + (dot_ext << 9) + (dot_ext << 5) + (dot_ext << 4) + dot_ext;
  assign prod    = PROD_W'(numer[NUMER_W-1:3]) * PROD_W'(SHADE_RECIP);

  assign shade_o = normals_present_i ? prod[SHADE_SHIFT+SHADE_W-1:SHADE_SHIFT]
                                     : SHADE_DEFAULT;

endmodule

`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench for the terrain vertex generator: grid walk, positions, texture and shade.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import tvg_pkg::*;

  localparam int GRID_CELLS   = 8;
  localparam int ROWS         = 2 * GRID_CELLS + 1;
  localparam int IDLE_LIMIT   = 1000;
  localparam int DRAIN_CYCLES = 4;
  localparam int HOLD_LENGTH  = 40;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic [TEX_W-1:0]        tex_u;
    logic [TEX_W-1:0]        tex_v;
    logic [SHADE_W-1:0]      shade;
    logic                    last_vertex;
  } vertex_t;

  logic clk;
  logic rst_n;

  tvg_cfg_if cfg ();
  tvg_in_if  vin ();
  tvg_out_if vout ();

  terrain_vertex_generator #(.GRID_CELLS(GRID_CELLS)) uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .cfg_i (cfg),
    .vtx_i (vin),
    .vtx_o (vout)
  );

  logic signed [COORD_W-1:0] base_x = '0;
  logic signed [COORD_W-1:0] base_y = '0;
  logic signed [COORD_W-1:0] base_z = '0;
  logic                      normals_on = 1'b0;
  int unsigned               row_idx = 0;
  int unsigned               col_idx = 0;
  vertex_t                   pending_vertices[$];
  int                        mismatches = 0;
  int                        results_seen = 0;
  int                        idle_cycles = 0;
  int                        hold_cycles = 0;
  bit                        steady_sender = 1'b0;
  bit                        steady_receiver = 1'b0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int half_step_offset(input int unsigned h);
    return (h * 25600 + 3 * GRID_CELLS) / (6 * GRID_CELLS);
  endfunction

  function automatic logic [COORD_W-1:0] random_coord();
    case ($urandom_range(0, 7))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'h000000;
      3: return 24'hFFFFFF;
      default: return COORD_W'($urandom);
    endcase
  endfunction

  task automatic check_field(input string field, input int expected, input int actual);
    if (expected != actual) begin
      mismatches++;
      if (mismatches <= 10)
        $display("vertex %0d: %s expected %0d, got %0d", results_seen, field, expected, actual);
    end
  endtask

  always @(posedge clk) begin
    int unsigned hc;
    int unsigned row_len;
    int          dot;
    vertex_t     v;
    if (vin.valid && vin.ready) begin
      row_len = row_idx[0] ? GRID_CELLS : GRID_CELLS + 1;
      hc      = row_idx[0] ? 2 * col_idx + 1 : 2 * col_idx;
      v.pos_x = POS_W'(int'(base_x) - half_step_offset(row_idx));
      v.pos_y = POS_W'(int'(base_y) - half_step_offset(hc));
      v.pos_z = POS_W'(int'(base_z) + int'(vin.height));
      v.tex_u = TEX_W'(hc * 8 / GRID_CELLS);
      v.tex_v = TEX_W'(row_idx * 8 / GRID_CELLS);
      if (normals_on) begin
        dot = -3 * int'(vin.normal_x) - 3 * int'(vin.normal_y) + 9 * int'(vin.normal_z);
        if (dot < 0) dot = 0;
        if (dot > 1270) dot = 1270;
        v.shade = SHADE_W'((582930 + 561 * dot) / 5080);
      end else begin
        v.shade = 8'd204;
      end
      v.last_vertex = (row_idx == 2 * GRID_CELLS) && (col_idx + 1 >= row_len);
      pending_vertices.push_back(v);
      col_idx++;
      if (col_idx >= row_len) begin
        col_idx = 0;
        row_idx = (row_idx + 1 >= ROWS) ? 0 : row_idx + 1;
      end
    end
    if (vout.valid && vout.ready) begin
      if (pending_vertices.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("vertex %0d: result with no request pending", results_seen);
      end else begin
        v = pending_vertices.pop_front();
        check_field("pos_x", int'(v.pos_x), int'(vout.pos_x));
        check_field("pos_y", int'(v.pos_y), int'(vout.pos_y));
        check_field("pos_z", int'(v.pos_z), int'(vout.pos_z));
        check_field("tex_u", int'(v.tex_u), int'(vout.tex_u));
        check_field("tex_v", int'(v.tex_v), int'(vout.tex_v));
        check_field("shade", int'(v.shade), int'(vout.shade));
        check_field("last_vertex", int'(v.last_vertex), int'(vout.last_vertex));
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    if ((vin.valid && vin.ready) || (vout.valid && vout.ready) || (cfg.valid && cfg.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int stall;
    int hold;
    vout.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        hold = hold_cycles;
        hold_cycles = 0;
        vout.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end else begin
        stall = steady_receiver ? 0 : $urandom_range(0, 11);
        if (stall > 0) begin
          vout.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      vout.ready <= 1'b1;
      do @(posedge clk); while (!(vout.valid && vout.ready) && hold_cycles == 0);
    end
  end

  task automatic send_vertex(input logic signed [COORD_W-1:0] height,
                             input logic signed [NORM_W-1:0] nx,
                             input logic signed [NORM_W-1:0] ny,
                             input logic signed [NORM_W-1:0] nz);
    int gap;
    gap = steady_sender ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      vin.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    vin.valid    <= 1'b1;
    vin.height   <= height;
    vin.normal_x <= nx;
    vin.normal_y <= ny;
    vin.normal_z <= nz;
    do @(posedge clk); while (!vin.ready);
  endtask

  task automatic send_random_vertex();
    int nx;
    int ny;
    int nz;
    if ($urandom_range(0, 2) == 0) begin
      nx = $urandom_range(0, 255) - 128;
      ny = $urandom_range(0, 255) - 128;
      nz = $urandom_range(0, 255) - 128;
    end else begin
      nx = $urandom_range(0, 120) - 60;
      ny = $urandom_range(0, 120) - 60;
      nz = $urandom_range(40, 127);
    end
    send_vertex(random_coord(), NORM_W'(nx), NORM_W'(ny), NORM_W'(nz));
  endtask

  task automatic wait_idle();
    vin.valid <= 1'b0;
    do @(posedge clk); while (pending_vertices.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    do @(posedge clk); while (!cfg.ready);
    case (idx)
      CFG_BASE_X:  base_x = value;
      CFG_BASE_Y:  base_y = value;
      CFG_BASE_Z:  base_z = value;
      CFG_NORMALS: normals_on = value[0];
      default: ;
    endcase
  endtask

  task automatic set_chunk_config(input logic [COORD_W-1:0] bx, input logic [COORD_W-1:0] by,
                                  input logic [COORD_W-1:0] bz, input logic normals);
    wait_idle();
    write_reg(CFG_BASE_X, bx);
    write_reg(CFG_BASE_Y, by);
    write_reg(CFG_BASE_Z, bz);
    write_reg(CFG_NORMALS, {23'($urandom), normals});
    cfg.valid <= 1'b0;
  endtask

  task automatic test_reset_values();
    send_vertex(24'sd0, 8'sd0, 8'sd0, 8'sd127);
    send_vertex(24'sd1000, -8'sd128, -8'sd128, 8'sd127);
    send_vertex(-24'sd1000, 8'sd127, 8'sd127, -8'sd128);
  endtask

  task automatic test_field_extremes();
    set_chunk_config(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 1'b1);
    send_vertex(24'h7FFFFF, -8'sd128, -8'sd128, 8'sd127);
    send_vertex(24'h800000, 8'sd127, 8'sd127, -8'sd128);
    send_vertex(24'h000000, 8'sd0, 8'sd0, 8'sd0);
    send_vertex(24'hFFFFFF, 8'sd0, 8'sd0, 8'sd127);
    send_vertex(24'h123456, -8'sd128, 8'sd127, 8'sd0);
    send_vertex(24'h7FFFFF, 8'sd0, 8'sd0, -8'sd128);
    send_vertex(24'h000001, -8'sd1, -8'sd1, -8'sd1);
    send_vertex(24'h654321, -8'sd40, -8'sd30, 8'sd100);
    set_chunk_config(24'h800000, 24'h7FFFFF, 24'h800000, 1'b0);
    send_vertex(24'h800000, -8'sd128, -8'sd128, 8'sd127);
    send_vertex(24'h7FFFFF, 8'sd127, 8'sd127, 8'sd127);
    send_vertex(24'hFFFFFF, -8'sd1, -8'sd1, -8'sd1);
    send_vertex(24'h000000, 8'sd0, 8'sd0, 8'sd0);
  endtask

  task automatic test_random_chunks();
    for (int phase = 0; phase < 7; phase++) begin
      steady_sender   = (phase == 0) || ($urandom_range(0, 3) == 0);
      steady_receiver = (phase == 0) || ($urandom_range(0, 3) == 0);
      set_chunk_config(random_coord(), random_coord(), random_coord(), (phase % 3) != 2);
      repeat (150) send_random_vertex();
    end
    steady_sender   = 1'b0;
    steady_receiver = 1'b0;
  endtask

  task automatic test_input_stall();
    steady_sender = 1'b1;
    hold_cycles   = HOLD_LENGTH;
    repeat (HOLD_LENGTH) send_random_vertex();
    steady_sender = 1'b0;
    wait_idle();
    repeat (20) send_random_vertex();
  endtask

  initial begin
    rst_n        = 1'b0;
    vin.valid    = 1'b0;
    vin.height   = '0;
    vin.normal_x = '0;
    vin.normal_y = '0;
    vin.normal_z = '0;
    cfg.valid    = 1'b0;
    cfg.index    = CFG_BASE_X;
    cfg.data     = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_values();
    test_field_extremes();
    test_random_chunks();
    test_input_stall();
    wait_idle();
    if (mismatches == 0 && pending_vertices.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
